>>> src/vsag_pkg.sv
`timescale 1ns / 1ps

package vsag_pkg;

	// field widths
	localparam int unsigned HPosW    = 9;
	localparam int unsigned VPosW    = 8;
	localparam int unsigned AddrW    = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 10;

	// bitmap wrap limits
	localparam logic [10:0] BmpWidth  = 11'd320;
	localparam logic [8:0]  BmpHeight = 9'd204;

	// fixed address offsets
	localparam logic [15:0] BmpWideBase  = 16'h1a00;
	localparam logic [15:0] Win32Base    = 16'h0200;
	localparam logic [15:0] Win40TextOff = 16'h0400;
	localparam logic [15:0] Win40GfxOff  = 16'h2000;
	localparam logic [15:0] Win32PageBit = 16'h8000;

	// display mode codes
	localparam logic [1:0] MODE_WIN32 = 2'd0;
	localparam logic [1:0] MODE_WIN40 = 2'd1;
	localparam logic [1:0] MODE_EXT   = 2'd2;

	// register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_DISPLAY_MODE  = 3'd0,
		REG_CHAR_MODE     = 3'd1,
		REG_GRAPH_MODE    = 3'd2,
		REG_CHAR_WIDTH_40 = 3'd3,
		REG_ROLL_X        = 3'd4,
		REG_ROLL_Y        = 3'd5,
		REG_TEXT_PAGE     = 3'd6,
		REG_ATTR_PAGE     = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [1:0] display_mode;
		logic       char_mode;
		logic       graph_mode;
		logic       char_width_40;
		logic [9:0] roll_x;
		logic [7:0] roll_y;
		logic [3:0] text_page;
		logic [1:0] attr_page;
	} cfg_t;

endpackage

>>> src/vsag_cfg_regs.sv
`timescale 1ns / 1ps

module vsag_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [vsag_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [vsag_pkg::CfgDataW-1:0]  cfg_data,
	output vsag_pkg::cfg_t                 cfg
);
	import vsag_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{display_mode: MODE_EXT, default: '0};
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				REG_DISPLAY_MODE:  cfg_q.display_mode  <= cfg_data[1:0];
				REG_CHAR_MODE:     cfg_q.char_mode     <= cfg_data[0];
				REG_GRAPH_MODE:    cfg_q.graph_mode    <= cfg_data[0];
				REG_CHAR_WIDTH_40: cfg_q.char_width_40 <= cfg_data[0];
				REG_ROLL_X:        cfg_q.roll_x        <= cfg_data[9:0];
				REG_ROLL_Y:        cfg_q.roll_y        <= cfg_data[7:0];
				REG_TEXT_PAGE:     cfg_q.text_page     <= cfg_data[3:0];
				REG_ATTR_PAGE:     cfg_q.attr_page     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/vsag_addr_calc.sv
`timescale 1ns / 1ps

module vsag_addr_calc (
	input  vsag_pkg::cfg_t                cfg,
	input  logic [vsag_pkg::HPosW-1:0]    h_pos,
	input  logic [vsag_pkg::VPosW-1:0]    v_pos,
	output logic [vsag_pkg::AddrW-1:0]    mem_addr
);
	import vsag_pkg::*;

	logic [9:0]  roll_x_m;
	logic [10:0] x_sum;
	logic [10:0] x_sub;
	logic [8:0]  x_wrap;
	logic [8:0]  y_sum;
	logic [8:0]  y_sub;
	logic [7:0]  y_wrap;
	logic [7:0]  y_perm;
	logic [15:0] bmp_addr;
	logic [15:0] v_x80;
	logic [15:0] v_x40;
	logic [15:0] v_x32;
	logic [15:0] h_ext;
	logic [15:0] legacy_raw;
	logic [15:0] base;
	logic [15:0] off;

	// bitmap coordinates, scrolled and wrapped (sum stays below five widths)
	assign roll_x_m = cfg.graph_mode ? cfg.roll_x : {cfg.roll_x[9:2], 2'b00};
	assign x_sum    = {2'b00, h_pos} + {1'b0, roll_x_m};

	always_comb begin
		if (x_sum >= 4 * BmpWidth)      x_sub = 11'(x_sum - 4 * BmpWidth);
		else if (x_sum >= 3 * BmpWidth) x_sub = 11'(x_sum - 3 * BmpWidth);
		else if (x_sum >= 2 * BmpWidth) x_sub = 11'(x_sum - 2 * BmpWidth);
		else if (x_sum >= BmpWidth)     x_sub = x_sum - BmpWidth;
		else                            x_sub = x_sum;
	end
	assign x_wrap = x_sub[8:0];

	assign y_sum = {1'b0, v_pos} + {1'b0, cfg.roll_y};
	always_comb begin
		if (y_sum >= 2 * BmpHeight)  y_sub = 9'(y_sum - 2 * BmpHeight);
		else if (y_sum >= BmpHeight) y_sub = y_sum - BmpHeight;
		else                         y_sub = y_sum;
	end
	assign y_wrap = y_sub[7:0];

	// narrow region rotates vertical bits 1..3: bit 1 moves up to bit 3, bits 3:2 drop to 2:1
	assign y_perm = {y_wrap[7:4], y_wrap[1], y_wrap[3:2], y_wrap[0]};

	always_comb begin
		if (!x_wrap[8]) begin
			bmp_addr = {1'b0, y_wrap[7:1], x_wrap[7:2], y_wrap[0], x_wrap[1]} + BmpWideBase;
		end else begin
			bmp_addr = {3'b000, y_perm[7:1], x_wrap[5:2], y_wrap[0], x_wrap[1]};
		end
	end

	// row strides as shift-and-add
	assign v_x32 = {3'b000, v_pos, 5'b00000};
	assign v_x40 = v_x32 + {5'b00000, v_pos, 3'b000};
	assign v_x80 = {v_x40[14:0], 1'b0};
	assign h_ext = {7'b0000000, h_pos};

	// legacy page bits from the attribute page register
	assign legacy_raw = {1'b0, ~cfg.attr_page[1], cfg.attr_page[0], 13'b0};

	always_comb begin
		if (cfg.display_mode[1]) begin
			base = {cfg.text_page[3], cfg.text_page[2:0] & {3{cfg.char_mode}}, 12'b0};
			if (cfg.char_mode) begin
				off = (cfg.char_width_40 ? v_x80 : {v_x80[14:0], 1'b0}) + h_ext;
			end else begin
				off = bmp_addr;
			end
		end else if (cfg.display_mode == MODE_WIN32) begin
			base = (legacy_raw | Win32PageBit) + Win32Base;
			off  = v_x32 + h_ext;
		end else begin
			base = {legacy_raw[14:0], 1'b0} + (cfg.char_mode ? Win40TextOff : Win40GfxOff);
			off  = v_x40 + h_ext;
		end
	end

	assign mem_addr = base + off;

endmodule

>>> src/vram_scan_address_generator.sv
`timescale 1ns / 1ps

// scan-side video ram address generator: each input word carries a scan
// position (h_pos, v_pos) and yields one 16-bit video ram byte address.
// the block takes one word per cycle while in_stall is low, and each word
// passes first through the input register, then through the result
// register; the address math between them is a handful of constant
// compares, shift-and-add strides and one 16-bit add. in_stall rises only
// while both registers hold words and out_stall is high. configuration is
// a plain write port (cfg_index picks the register, cfg_data carries the
// value) and must only be written while no word is in flight; the page
// offset follows the window mode in force when the address is formed.

module vram_scan_address_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_wr_en,
	input  logic [vsag_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [vsag_pkg::CfgDataW-1:0]  cfg_data,
	// scan position input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [vsag_pkg::HPosW-1:0]     h_pos,
	input  logic [vsag_pkg::VPosW-1:0]     v_pos,
	// address output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [vsag_pkg::AddrW-1:0]     mem_addr
);
	import vsag_pkg::*;

	cfg_t               cfg;
	logic               valid_s1;
	logic [HPosW-1:0]   h_pos_s1;
	logic [VPosW-1:0]   v_pos_s1;
	logic               valid_s2;
	logic [AddrW-1:0]   addr_s2;
	logic [AddrW-1:0]   addr_next;
	logic               load_s2;
	logic               load_s1;

	vsag_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register frees up when empty or being taken
	assign load_s2  = !valid_s2 || !out_stall;
	// input register moves when empty or when its word goes forward
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			h_pos_s1 <= h_pos;
			v_pos_s1 <= v_pos;
		end
	end

	// address math on the registered position
	vsag_addr_calc u_calc (
		.cfg      (cfg),
		.h_pos    (h_pos_s1),
		.v_pos    (v_pos_s1),
		.mem_addr (addr_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			addr_s2 <= addr_next;
		end
	end

	assign out_valid = valid_s2;
	assign mem_addr  = addr_s2;

endmodule

>>> tb/vsag_addr_checker.sv
`timescale 1ns / 1ps

module vsag_addr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [vsag_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [vsag_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [vsag_pkg::HPosW-1:0]     h_pos,
	input  logic [vsag_pkg::VPosW-1:0]     v_pos,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [vsag_pkg::AddrW-1:0]     mem_addr,
	output int                             mismatch_count,
	output int                             words_in_flight
);

	import vsag_pkg::*;

	cfg_t             shadow_cfg;
	logic [AddrW-1:0] addr_queue[$];
	logic [AddrW-1:0] want_addr;
	int               errs;

	function automatic logic [15:0] bitmap_addr(cfg_t c, logic [8:0] h, logic [7:0] v);
		int x, y, a;
		x = int'(h) + int'(c.roll_x & (c.graph_mode ? 10'h3ff : 10'h3fc));
		y = int'(v) + int'(c.roll_y);
		x = x % int'(BmpWidth);
		y = y % int'(BmpHeight);
		if (x < 256) begin
			a = x + (y >> 1) * 256;
		end else begin
			// narrow region: old bit 1 goes to bit 3, old bits 3:2 drop to 2:1
			y = (y & 'hfff1) | ((y & 2) << 2) | ((y & 'hc) >> 1);
			a = (x - 256) + (y >> 1) * 64;
		end
		a = (a & 'hfffc) | ((y & 1) << 1) | ((x & 2) >> 1);
		if (x < 256)
			a = a + int'(BmpWideBase);
		return a[15:0];
	endfunction

	function automatic logic [15:0] predict_addr(cfg_t c, logic [8:0] h, logic [7:0] v);
		logic [15:0] base, off, page;
		page = {1'b0, ~c.attr_page[1], c.attr_page[0], 13'd0};
		if (c.display_mode[1]) begin
			// bitmap keeps only the top page bit
			base = c.char_mode ? {c.text_page, 12'd0} : {c.text_page[3], 15'd0};
			if (c.char_mode)
				off = 16'(v) * (c.char_width_40 ? 16'd80 : 16'd160) + 16'(h);
			else
				off = bitmap_addr(c, h, v);
		end else if (c.display_mode == MODE_WIN32) begin
			base = (page | Win32PageBit) + Win32Base;
			off = {3'd0, v, 5'd0} + 16'(h);
		end else begin
			base = {page[14:0], 1'b0} + (c.char_mode ? Win40TextOff : Win40GfxOff);
			off = 16'(v) * 16'd40 + 16'(h);
		end
		return base + off;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_cfg = '0;
			shadow_cfg.display_mode = MODE_EXT;
			addr_queue.delete();
			errs = 0;
			mismatch_count <= 0;
			words_in_flight <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (addr_queue.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual mem_addr %h",
						$time, mem_addr);
					errs++;
				end else begin
					want_addr = addr_queue.pop_front();
					if (mem_addr !== want_addr) begin
						$display("%0t: mem_addr mismatch, expected %h, actual %h",
							$time, want_addr, mem_addr);
						errs++;
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DISPLAY_MODE:  shadow_cfg.display_mode = cfg_data[1:0];
					REG_CHAR_MODE:     shadow_cfg.char_mode = cfg_data[0];
					REG_GRAPH_MODE:    shadow_cfg.graph_mode = cfg_data[0];
					REG_CHAR_WIDTH_40: shadow_cfg.char_width_40 = cfg_data[0];
					REG_ROLL_X:        shadow_cfg.roll_x = cfg_data[9:0];
					REG_ROLL_Y:        shadow_cfg.roll_y = cfg_data[7:0];
					REG_TEXT_PAGE:     shadow_cfg.text_page = cfg_data[3:0];
					REG_ATTR_PAGE:     shadow_cfg.attr_page = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				addr_queue.push_back(predict_addr(shadow_cfg, h_pos, v_pos));
			mismatch_count <= errs;
			words_in_flight <= addr_queue.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import vsag_pkg::*;

	// run length and safety net
	localparam int RandWords = 1900;
	localparam int CalmWords = 1700;   // past this count nobody idles
	localparam int CycleLimit = 400000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [HPosW-1:0]    h_pos = '0;
	logic [VPosW-1:0]    v_pos = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [AddrW-1:0]    mem_addr;

	int   mismatch_count;
	int   words_in_flight;
	int   cycles = 0;
	logic calm_tail = 1'b0;
	logic gap_on = 1'b0;
	int   stall_left = 0;
	int   quiet_left = 0;

	vram_scan_address_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.h_pos     (h_pos),
		.v_pos     (v_pos),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mem_addr  (mem_addr)
	);

	vsag_addr_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.h_pos           (h_pos),
		.v_pos           (v_pos),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mem_addr        (mem_addr),
		.mismatch_count  (mismatch_count),
		.words_in_flight (words_in_flight)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// hard stop in case a handshake hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver back-pressure: random stall bursts, broken up by long quiet
	// stretches; no stalls at all during the calm tail
	always @(posedge clk) begin
		if (calm_tail || !arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (quiet_left > 0) begin
			out_stall <= 1'b0;
			quiet_left <= quiet_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 39) == 0)
				quiet_left <= $urandom_range(50, 200);
		end
	end

	// pick an end of the range or anything in between
	function automatic int pick_edge(int hi);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return hi;
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	function automatic cfg_t make_cfg(logic [1:0] mode, logic chr, logic gfx, logic w40,
			logic [9:0] rx, logic [7:0] ry, logic [3:0] tp, logic [1:0] ap);
		cfg_t c;
		c.display_mode = mode;
		c.char_mode = chr;
		c.graph_mode = gfx;
		c.char_width_40 = w40;
		c.roll_x = rx;
		c.roll_y = ry;
		c.text_page = tp;
		c.attr_page = ap;
		return c;
	endfunction

	function automatic cfg_t random_cfg();
		return make_cfg(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			10'(pick_edge(1023)), 8'(pick_edge(255)), 4'(pick_edge(15)),
			2'($urandom_range(0, 3)));
	endfunction

	// write data for one register; bits above the register width carry junk,
	// which the block is expected to drop
	function automatic logic [CfgDataW-1:0] reg_word(cfg_t c, cfg_index_t idx);
		logic [CfgDataW-1:0] junk;
		junk = CfgDataW'($urandom);
		case (idx)
			REG_DISPLAY_MODE:  return {junk[9:2], c.display_mode};
			REG_CHAR_MODE:     return {junk[9:1], c.char_mode};
			REG_GRAPH_MODE:    return {junk[9:1], c.graph_mode};
			REG_CHAR_WIDTH_40: return {junk[9:1], c.char_width_40};
			REG_ROLL_X:        return c.roll_x;
			REG_ROLL_Y:        return {junk[9:8], c.roll_y};
			REG_TEXT_PAGE:     return {junk[9:4], c.text_page};
			default:           return {junk[9:2], c.attr_page};
		endcase
	endfunction

	// stop sending and hold off until every address has come back
	task automatic drain_words();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
	endtask

	// back-to-back writes of all eight registers; the block is idle here
	task automatic load_config(cfg_t c);
		cfg_index_t idx;
		drain_words();
		for (int i = 0; i < 8; i++) begin
			idx = cfg_index_t'(i);
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_data <= reg_word(c, idx);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// one scan position; an optional sender gap goes in front of it, and valid
	// stays high straight into the next word when there is no gap
	task automatic send_word(logic [HPosW-1:0] h, logic [VPosW-1:0] v);
		if (gap_on && !calm_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		h_pos <= h;
		v_pos <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// corners of the scan plus one arbitrary position
	task automatic corner_words();
		send_word('0, '0);
		send_word('1, '1);
		send_word(HPosW'($urandom), VPosW'($urandom));
	endtask

	initial begin
		int sent;
		int run_len;
		logic [HPosW-1:0] h;
		logic [VPosW-1:0] v;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// reset state: extended bitmap, no scroll, page zero
		gap_on <= 1'b1;
		corner_words();
		// 32-column window, page bits clear and set
		load_config(make_cfg(MODE_WIN32, 1'b0, 1'b0, 1'b0, 10'd0, 8'd0, 4'd0, 2'd0));
		corner_words();
		load_config(make_cfg(MODE_WIN32, 1'b1, 1'b0, 1'b0, 10'd0, 8'd0, 4'd15, 2'd3));
		corner_words();
		// 40-column window, text and graphics offsets
		load_config(make_cfg(MODE_WIN40, 1'b1, 1'b0, 1'b0, 10'd0, 8'd0, 4'd0, 2'd1));
		corner_words();
		load_config(make_cfg(MODE_WIN40, 1'b0, 1'b1, 1'b1, 10'd1023, 8'd255, 4'd15, 2'd2));
		corner_words();
		// extended text, 80 and 40 columns
		load_config(make_cfg(MODE_EXT, 1'b1, 1'b0, 1'b0, 10'd0, 8'd0, 4'd15, 2'd0));
		corner_words();
		load_config(make_cfg(MODE_EXT, 1'b1, 1'b1, 1'b1, 10'd512, 8'd128, 4'd5, 2'd3));
		corner_words();
		// extended bitmap with full scroll; narrow region edges
		load_config(make_cfg(MODE_EXT, 1'b0, 1'b1, 1'b0, 10'd1023, 8'd255, 4'd15, 2'd0));
		send_word(9'd0, 8'd0);
		send_word(9'd511, 8'd255);
		send_word(9'd256, 8'd0);
		// unused mode code behaves as extended; masked scroll low bits
		load_config(make_cfg(2'd3, 1'b0, 1'b0, 1'b1, 10'd3, 8'd203, 4'd8, 2'd1));
		send_word(9'd256, 8'd0);
		send_word(9'd319, 8'd203);
		send_word(9'd255, 8'd1);

		// --- random part: phases of random settings ---
		sent = 0;
		while (sent < RandWords) begin
			load_config(random_cfg());
			gap_on <= ($urandom_range(0, 2) != 0);
			run_len = $urandom_range(20, 120);
			for (int i = 0; i < run_len && sent < RandWords; i++) begin
				h = HPosW'($urandom);
				v = VPosW'($urandom);
				// now and then land right on the wrap and region edges
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 3))
						0: h = 9'd255;
						1: h = 9'd256;
						2: h = 9'd319;
						default: h = 9'd320;
					endcase
					v = ($urandom_range(0, 1) != 0) ? 8'd203 : 8'd204;
				end
				send_word(h, v);
				sent++;
				if (sent == CalmWords)
					calm_tail <= 1'b1;
			end
		end

		// --- wind down ---
		drain_words();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> sim.f
src/vsag_pkg.sv
src/vsag_cfg_regs.sv
src/vsag_addr_calc.sv
src/vram_scan_address_generator.sv
tb/vsag_addr_checker.sv
tb/testbench.sv
